// ===== hdl/voip_src_pkg.sv =====
// ----------------------------------------------------------------------------
// voip_src_pkg
// Shared types and constants for the on/off voice traffic source.
// ----------------------------------------------------------------------------
package voip_src_pkg;

  // request opcodes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_TALKING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SILENT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_TALKING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_SILENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_USED   = 3'd4;
  localparam int CFG_DATA_W = 16;

  // reset values of the configuration registers
  localparam logic [9:0]  RST_RATE_TALKING = 10'd370;
  localparam logic [9:0]  RST_RATE_SILENT  = 10'd37;
  localparam logic [15:0] RST_SIZE_TALKING = 16'd33;
  localparam logic [15:0] RST_SIZE_SILENT  = 16'd7;
  localparam logic [7:0]  RST_TABLE_USED   = 8'd100;

  localparam logic [19:0] NS_PER_TICK = 20'd1000000;

  typedef struct packed {
    logic        func;
    logic [9:0]  random_value;
    logic [6:0]  entry_index;
    logic [15:0] entry_value;
  } in_req_t;

  typedef struct packed {
    logic [15:0] packet_size;
    logic [31:0] gap_ticks;
    logic [51:0] gap_ns;
    logic        talking;
  } out_res_t;

  typedef struct packed {
    logic [9:0]  rate_talking;
    logic [9:0]  rate_silent;
    logic [15:0] size_talking;
    logic [15:0] size_silent;
    logic [7:0]  table_used;
  } cfg_t;

  // tick result before the ns conversion
  typedef struct packed {
    logic        send;
    logic [15:0] packet_size;
    logic [31:0] gap_ticks;
    logic        talking;
  } tick_res_t;

  typedef struct packed {
    logic talking;
    logic scheduled;
  } tick_st_t;

endpackage

// ===== hdl/voip_src_dur_mem.sv =====
// ----------------------------------------------------------------------------
// voip_src_dur_mem
// Period duration table: one write port, one registered read port with
// same-cycle write forwarding.
// ----------------------------------------------------------------------------
module voip_src_dur_mem #(
  parameter int TABLE_DEPTH = 128,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [TABLE_DEPTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // forward a write landing on the entry being fetched
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/voip_src_tick.sv =====
// ----------------------------------------------------------------------------
// voip_src_tick
// Per-tick state update: send decision, gap, period end and table position.
// ----------------------------------------------------------------------------
module voip_src_tick
  import voip_src_pkg::*;
#(
  parameter int TABLE_DEPTH = 128,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          step_en,
  input  logic [9:0]    draw,
  input  logic [15:0]   tbl_data,
  output logic [AW-1:0] rd_addr,
  output tick_res_t     res,
  output tick_st_t      st
);

  localparam int LW = $clog2(TABLE_DEPTH + 1);

  logic [31:0]   tick_r, tick_nxt;
  logic [31:0]   last_r, last_nxt;
  logic [31:0]   next_r, next_nxt;
  logic          talk_r, talk_nxt;
  logic          sched_r, sched_nxt;
  logic [AW-1:0] pos_r, pos_nxt;

  logic [LW-1:0] used_lim;
  logic [LW-1:0] pos_inc;
  logic [31:0]   tick_inc;
  logic [31:0]   since_end;
  logic [9:0]    rate_sel;
  logic          send;
  logic          due;

  // entries in use, clamped to 1..TABLE_DEPTH
  always_comb begin
    if (cfg.table_used == 8'd0) begin
      used_lim = LW'(1);
    end else if (32'(cfg.table_used) > 32'(TABLE_DEPTH)) begin
      used_lim = LW'(TABLE_DEPTH);
    end else begin
      used_lim = LW'(cfg.table_used);
    end
  end

  assign tick_inc  = tick_r + 32'd1;
  assign since_end = tick_inc - next_r;
  assign rate_sel  = talk_r ? cfg.rate_talking : cfg.rate_silent;
  assign send      = draw < rate_sel;
  assign due       = !sched_r || !since_end[31];
  assign pos_inc   = LW'(pos_r) + LW'(1);

  always_comb begin
    tick_nxt  = tick_r;
    last_nxt  = last_r;
    next_nxt  = next_r;
    talk_nxt  = talk_r;
    sched_nxt = sched_r;
    pos_nxt   = pos_r;
    if (step_en) begin
      tick_nxt = tick_inc;
      if (send) begin
        last_nxt = tick_inc;
      end
      if (due) begin
        talk_nxt  = sched_r ? !talk_r : talk_r;
        sched_nxt = 1'b1;
        next_nxt  = tick_inc + 32'(tbl_data);
        pos_nxt   = (pos_inc >= used_lim) ? '0 : AW'(pos_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      last_r  <= '0;
      next_r  <= '0;
      talk_r  <= 1'b1;
      sched_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      tick_r  <= tick_nxt;
      last_r  <= last_nxt;
      next_r  <= next_nxt;
      talk_r  <= talk_nxt;
      sched_r <= sched_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // fetch the entry the position will point at next cycle
  assign rd_addr = rst_n ? pos_nxt : '0;

  assign res.send        = step_en && send;
  assign res.packet_size = talk_nxt ? cfg.size_talking : cfg.size_silent;
  assign res.gap_ticks   = tick_inc - last_r;
  assign res.talking     = talk_nxt;

  assign st.talking   = talk_r;
  assign st.scheduled = sched_r;

endmodule

// ===== hdl/voip_src_out.sv =====
// ----------------------------------------------------------------------------
// voip_src_out
// Result buffer then ns conversion into the output register.
// ----------------------------------------------------------------------------
module voip_src_out
  import voip_src_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tick_res_t res,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_res_t  out_data
);

  logic      s1_valid_r;
  tick_res_t s1_r;
  logic      o_valid_r;
  out_res_t  o_data_r;
  logic      o_hold;
  logic      s1_move;

  assign o_hold  = o_valid_r && out_stall;
  assign s1_move = s1_valid_r && !o_hold;
  assign full    = s1_valid_r && o_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= res.send || (s1_valid_r && !s1_move);
      o_valid_r  <= s1_move || o_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (res.send) begin
      s1_r <= res;
    end
    if (s1_move) begin
      o_data_r.packet_size <= s1_r.packet_size;
      o_data_r.gap_ticks   <= s1_r.gap_ticks;
      o_data_r.gap_ns      <= 52'(s1_r.gap_ticks) * 52'(NS_PER_TICK);
      o_data_r.talking     <= s1_r.talking;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

endmodule

// ===== hdl/voip_on_off_traffic_source_core.sv =====
// ----------------------------------------------------------------------------
// voip_on_off_traffic_source_core
// On/off voice packet source stepped one tick per tick request.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload     direction
//  in_      in_valid / in_stall   in_req_t    tick or table load request
//  out_     out_valid / out_stall out_res_t   packet to send
//  cfg_     cfg_valid / cfg_ready index+data  register write
//
// One request per cycle while in_stall is low. A tick updates all state in
// the cycle it is taken; the duration entry it may need was fetched the cycle
// before from the table's registered read port, addressed by the next position.
// A send passes the result buffer, then the 32x20 ns multiply into the output
// register, before it reaches out_.
// Reset (synchronous, rst_n low) clears the counters, the result buffer and
// the output register; the table keeps its contents and needs no sweep.
// in_stall rises only when the output register is stalled and the buffer
// behind it also holds a result. cfg_ready is always high.
//
module voip_on_off_traffic_source_core
  import voip_src_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_res_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  cfg_t          cfg_r;
  logic          in_fire;
  logic          tick_fire;
  logic          load_fire;
  logic          wr_ok;
  logic [AW-1:0] rd_addr;
  logic [15:0]   tbl_data;
  tick_res_t     tick_res;
  tick_st_t      tick_st;
  logic          buf_full;

  // --- configuration registers --------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate_talking <= RST_RATE_TALKING;
      cfg_r.rate_silent  <= RST_RATE_SILENT;
      cfg_r.size_talking <= RST_SIZE_TALKING;
      cfg_r.size_silent  <= RST_SIZE_SILENT;
      cfg_r.table_used   <= RST_TABLE_USED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RATE_TALKING: cfg_r.rate_talking <= cfg_data[9:0];
        CFG_RATE_SILENT:  cfg_r.rate_silent  <= cfg_data[9:0];
        CFG_SIZE_TALKING: cfg_r.size_talking <= cfg_data;
        CFG_SIZE_SILENT:  cfg_r.size_silent  <= cfg_data;
        CFG_TABLE_USED:   cfg_r.table_used   <= cfg_data[7:0];
        default: ;        // unmapped index, dropped
      endcase
    end
  end

  // --- request decode ------------------------------------------------------
  assign in_stall  = buf_full;
  assign in_fire   = in_valid && !in_stall;
  assign tick_fire = in_fire && (in_data.func == FUNC_TICK);
  assign load_fire = in_fire && (in_data.func == FUNC_LOAD);
  // loads past the table are dropped
  assign wr_ok     = 32'(in_data.entry_index) < 32'(TABLE_DEPTH);

  // --- duration table -------------------------------------------------------
  voip_src_dur_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load_fire && wr_ok),
    .wr_addr (AW'(in_data.entry_index)),
    .wr_data (in_data.entry_value),
    .rd_addr (rd_addr),
    .rd_data (tbl_data)
  );

  // --- tick state -----------------------------------------------------------
  voip_src_tick #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_tick (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .step_en  (tick_fire),
    .draw     (in_data.random_value),
    .tbl_data (tbl_data),
    .rd_addr  (rd_addr),
    .res      (tick_res),
    .st       (tick_st)
  );

  // --- result buffer and output ---------------------------------------------
  voip_src_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (tick_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // --- assertions -----------------------------------------------------------
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_gap_ns: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.gap_ns == 52'(out_data.gap_ticks) * 52'(NS_PER_TICK)))
    else $error("gap_ns does not match gap_ticks");

  a_toggle_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (tick_st.talking != $past(tick_st.talking))) |->
      ($past(tick_fire) && $past(tick_st.scheduled)))
    else $error("talk state changed without a scheduled tick");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the on/off voice traffic source core.
// A short table of hand-picked loads and ticks comes first, then phases of
// random requests under several register settings. Both sides idle and stall
// at random. A behavioural copy of the source predicts each packet not typed
// in the table; every packet is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
  import voip_src_pkg::*;

  localparam int TBL_DEPTH    = 128;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 8;     // result buffer and output register, with margin
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int STALL_LIMIT  = 3000;  // cycles with no handshake at all
  localparam int PHASE_REQS   = 275;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid;
  logic                  in_stall;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_res_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  voip_on_off_traffic_source_core #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioural copy of the source: registers, counters and duration table.
  // --------------------------------------------------------------------------
  logic [9:0]  rate_tk;
  logic [9:0]  rate_sl;
  logic [15:0] size_tk;
  logic [15:0] size_sl;
  logic [7:0]  tab_used;
  logic [31:0] tick_no;
  logic [31:0] prev_send;
  logic [31:0] next_end;
  logic        talking_now;
  logic        end_sched;
  int          tab_pos;
  logic [15:0] dur_tab [TBL_DEPTH];
  bit          entry_loaded [TBL_DEPTH];

  out_res_t    pending_pkts[$];   // packets predicted, not yet seen
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          calm_in = 1'b0;    // no sender gaps in this phase
  bit          calm_out = 1'b0;   // no receiver stalls in this phase
  bit          hold_out = 1'b0;   // ask the receiver for one long hold-off

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_RATE_TALKING: rate_tk  = val[9:0];
      CFG_RATE_SILENT:  rate_sl  = val[9:0];
      CFG_SIZE_TALKING: size_tk  = val;
      CFG_SIZE_SILENT:  size_sl  = val;
      CFG_TABLE_USED:   tab_used = val[7:0];
      default: ;        // spare indexes write nothing
    endcase
  endfunction

  // One request through the source. Loads only fill the table; a tick counts
  // up, decides the send on the state before any toggle, then handles the
  // period end (the first one only schedules, later ones toggle too).
  task automatic step_source(input in_req_t r, output bit sent, output out_res_t pkt);
    logic [31:0] gap;
    logic [31:0] lag;
    int          lim;
    sent = 1'b0;
    pkt  = '0;
    gap  = '0;
    if (r.func == FUNC_LOAD) begin
      dur_tab[r.entry_index]      = r.entry_value;
      entry_loaded[r.entry_index] = 1'b1;
    end else begin
      tick_no = tick_no + 32'd1;
      sent = r.random_value < (talking_now ? rate_tk : rate_sl);
      if (sent) begin
        gap       = tick_no - prev_send;
        prev_send = tick_no;
      end
      // wrap-aware: reached when the difference is "non-negative"
      lag = tick_no - next_end;
      if (!end_sched || !lag[31]) begin
        if (end_sched) talking_now = !talking_now;
        end_sched = 1'b1;
        next_end  = tick_no + {16'd0, dur_tab[tab_pos]};
        // length 0 acts as 1, above the depth saturates
        lim = (tab_used == 8'd0) ? 1 : (tab_used > TBL_DEPTH) ? TBL_DEPTH : int'(tab_used);
        // entry at a position past a reduced length is still used, then wrap
        tab_pos = (tab_pos + 1 >= lim) ? 0 : tab_pos + 1;
      end
      pkt.packet_size = talking_now ? size_tk : size_sl;
      pkt.gap_ticks   = gap;
      pkt.gap_ns      = {20'd0, gap} * {32'd0, NS_PER_TICK};
      pkt.talking     = talking_now;
    end
  endtask

  // True when the next tick would fetch a duration never loaded.
  function automatic bit tick_reads_unloaded();
    logic [31:0] lag;
    lag = tick_no + 32'd1 - next_end;
    return (!end_sched || !lag[31]) && !entry_loaded[tab_pos];
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic in_req_t random_req(input bit big_ok);
    in_req_t r;
    int      lim;
    int      p;
    r.func = ($urandom_range(0, 4) == 0) ? FUNC_LOAD : FUNC_TICK;
    // draws above 999 now and then, compared raw
    if ($urandom_range(0, 19) == 0) r.random_value = 10'($urandom_range(1000, 1023));
    else                            r.random_value = 10'($urandom_range(0, 999));
    r.entry_index = 7'($urandom_range(0, TBL_DEPTH - 1));
    r.entry_value = 16'($urandom);
    if (r.func == FUNC_LOAD) begin
      lim = (tab_used == 8'd0) ? 1 : (tab_used > TBL_DEPTH) ? TBL_DEPTH : int'(tab_used);
      if ($urandom_range(0, 9) < 7) r.entry_index = 7'($urandom_range(0, lim - 1));
      // short periods keep the state toggling; long ones only near the end
      p = $urandom_range(0, 99);
      if (big_ok && p < 5) r.entry_value = 16'($urandom);
      else if (p < 15)     r.entry_value = 16'($urandom_range(0, 255));
      else                 r.entry_value = 16'($urandom_range(0, 12));
    end
    return r;
  endfunction

  task automatic report_err(input string what, input logic [63:0] got,
                            input logic [63:0] want);
    err_count++;
    $display("tb: %0t ns: %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Request side. Each request is predicted at the edge that accepts it;
  // valid stays high when the next request follows at once.
  // --------------------------------------------------------------------------
  task automatic push_req(input in_req_t r, output bit sent, output out_res_t pkt);
    int n;
    n = calm_in ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    step_source(r, sent, pkt);
  endtask

  // Sends one request, loading the entry first if the tick would read an
  // entry that was never written. A typed expectation overrides the predictor.
  task automatic issue(input in_req_t r, input bit typed, input bit has_pkt,
                       input out_res_t want);
    in_req_t  fill;
    bit       sent;
    out_res_t pkt;
    if (r.func == FUNC_TICK && tick_reads_unloaded()) begin
      fill             = random_req(1'b0);
      fill.func        = FUNC_LOAD;
      fill.entry_index = 7'(tab_pos);
      fill.entry_value = 16'($urandom_range(0, 12));
      push_req(fill, sent, pkt);
    end
    push_req(r, sent, pkt);
    if (typed) begin
      if (has_pkt) pending_pkts.push_back(want);
    end else if (sent) begin
      pending_pkts.push_back(pkt);
    end
  endtask

  // Block idle: every packet out, plus the pipeline latency for ticks that
  // sent nothing. Valid is dropped in the step of the last acceptance.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pkts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic run_phase(input logic [15:0] rt, input logic [15:0] rs,
                           input logic [15:0] st, input logic [15:0] ss,
                           input logic [15:0] used, input bit spare_writes,
                           input bit press, input bit big_ok);
    settle();
    write_reg(CFG_RATE_TALKING, rt);
    write_reg(CFG_RATE_SILENT, rs);
    write_reg(CFG_SIZE_TALKING, st);
    write_reg(CFG_SIZE_SILENT, ss);
    write_reg(CFG_TABLE_USED, used);
    // indexes past the register list must leave everything alone
    if (spare_writes)
      for (int k = int'(CFG_TABLE_USED) + 1; k < (1 << CFG_IDX_W); k++)
        write_reg(CFG_IDX_W'(k), 16'($urandom));
    cfg_valid <= 1'b0;
    calm_in  = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    if (press) begin
      calm_in  = 1'b1;
      hold_out = 1'b1;
    end
    repeat (PHASE_REQS) issue(random_req(big_ok), 1'b0, 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    in_req_t  req;
    bit       typed;
    bit       has_pkt;
    out_res_t pkt;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(input logic fn, input int draw, input int idx,
                                  input int val, input bit typed = 1'b0,
                                  input bit has_pkt = 1'b0, input int sz = 0,
                                  input int gap = 0, input logic [51:0] ns = '0,
                                  input bit talk = 1'b0);
    dir_row_t row;
    row.req.func         = fn;
    row.req.random_value = 10'(draw);
    row.req.entry_index  = 7'(idx);
    row.req.entry_value  = 16'(val);
    row.typed            = typed;
    row.has_pkt          = has_pkt;
    row.pkt.packet_size  = 16'(sz);
    row.pkt.gap_ticks    = 32'(gap);
    row.pkt.gap_ns       = ns;
    row.pkt.talking      = talk;
    dir_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    rate_tk     = RST_RATE_TALKING;
    rate_sl     = RST_RATE_SILENT;
    size_tk     = RST_SIZE_TALKING;
    size_sl     = RST_SIZE_SILENT;
    tab_used    = RST_TABLE_USED;
    tick_no     = '0;
    prev_send   = '0;
    next_end    = '0;
    talking_now = 1'b1;
    end_sched   = 1'b0;
    tab_pos     = 0;
    foreach (entry_loaded[i]) begin
      entry_loaded[i] = 1'b0;
      dur_tab[i]      = '0;
    end

    // Register reset values are in force here. Loads carry noise in the
    // draw field, ticks in the entry fields; both must be ignored.
    add_row(FUNC_LOAD, 1023, 0, 3);
    add_row(FUNC_LOAD, 0, 1, 0);              // zero duration
    add_row(FUNC_LOAD, 0, 2, 2);
    add_row(FUNC_LOAD, 0, 3, 1);
    add_row(FUNC_LOAD, 0, 4, 2);
    add_row(FUNC_LOAD, 0, 127, 16'hFFFF);     // top index, longest period
    // first tick: schedules the first end without toggling, gap from tick 0
    add_row(FUNC_TICK, 0, 0, 0, 1, 1, 33, 1, 52'd1000000, 1'b1);
    add_row(FUNC_TICK, 369, 127, 16'hFFFF, 1, 1, 33, 1, 52'd1000000, 1'b1);
    add_row(FUNC_TICK, 370, 0, 0, 1, 0);      // draw equal to the rate: no send
    add_row(FUNC_TICK, 1023, 0, 0, 1, 0);     // first toggle, to silent
    add_row(FUNC_TICK, 36, 0, 0);             // just under the silent rate
    add_row(FUNC_TICK, 999, 0, 0);
    add_row(FUNC_TICK, 0, 0, 0);
    add_row(FUNC_TICK, 37, 0, 0);
    add_row(FUNC_TICK, 0, 0, 0);
    add_row(FUNC_TICK, 0, 0, 0);
    add_row(FUNC_LOAD, 0, 127, 5);            // keep the top entry short later on
    add_row(FUNC_TICK, 500, 0, 0);
    add_row(FUNC_TICK, 0, 0, 0);
    add_row(FUNC_TICK, 1000, 0, 0);
    add_row(FUNC_TICK, 0, 0, 0);
    add_row(FUNC_TICK, 36, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].has_pkt, dir_rows[i].pkt);

    // all-ones rate data (raw 1023), silent never sends, table length 0
    run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
    // nearly every tick sends; long receiver hold-off fills the block
    run_phase(16'd1000, 16'd1000, 16'h0000, 16'hFFFF, 16'd128, 1'b1, 1'b1, 1'b0);
    // talking never sends; length above the depth saturates
    run_phase(16'd0, 16'd30, 16'($urandom), 16'($urandom), 16'd255, 1'b0, 1'b0, 1'b0);
    run_phase(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)),
              16'($urandom), 16'($urandom), 16'($urandom_range(1, 128)),
              1'b0, 1'b0, 1'b0);
    // short table while the position may sit far beyond it
    run_phase(16'd370, 16'd37, 16'd33, 16'd7, 16'd3, 1'b0, 1'b0, 1'b0);
    run_phase(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
              16'($urandom), 16'($urandom), 16'($urandom_range(0, 255)),
              1'b1, 1'b0, 1'b1);

    settle();
    if (err_count == 0) $display("tb: done, clean");
    else                $display("tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and one long hold-off on demand.
  // --------------------------------------------------------------------------
  initial begin : out_side
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stall_left == 0 && !calm_out) stall_left = gap_len();
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Packet checker: oldest prediction first.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pkts.size() == 0) begin
        report_err("packet with none predicted, gap", out_data.gap_ticks, '0);
      end else begin
        if (out_data.packet_size !== pending_pkts[0].packet_size)
          report_err("packet_size", out_data.packet_size, pending_pkts[0].packet_size);
        if (out_data.gap_ticks !== pending_pkts[0].gap_ticks)
          report_err("gap_ticks", out_data.gap_ticks, pending_pkts[0].gap_ticks);
        if (out_data.gap_ns !== pending_pkts[0].gap_ns)
          report_err("gap_ns", out_data.gap_ns, pending_pkts[0].gap_ns);
        if (out_data.talking !== pending_pkts[0].talking)
          report_err("talking", out_data.talking, pending_pkts[0].talking);
        void'(pending_pkts.pop_front());
      end
    end
  end

  // Watchdog: ends the run when no channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
hdl/voip_src_pkg.sv
hdl/voip_src_dur_mem.sv
hdl/voip_src_tick.sv
hdl/voip_src_out.sv
hdl/voip_on_off_traffic_source_core.sv
test/tb.sv
